### sv/jfps_pkg.sv
// Package for the five-point Jacobi stencil: widths, reset values and the
// constant divide-by-five helper used by the result pipeline.
// No dependencies; used by jacobi_five_point_stencil.
package jfps_pkg;

    // Default largest interior edge length.
    localparam int MAX_GRID_DEF = 2048;

    // Reset value of the grid_size register.
    localparam int GRID_RESET = 2048;

    // Field widths.
    localparam int CFG_W    = 12;
    localparam int SAMPLE_W = 32;

    // Width of the offset five-sample sum. The offset makes it non-negative.
    localparam int SUM_W = 35;

    // Offset added to the signed sum: 2 for rounding and 5 * 2^31 to lift it
    // above zero. floor((sum + 2) / 5) is the rounded quotient.
    localparam logic signed [SUM_W:0] SUM_OFFSET = 36'sd10737418242;

    // Reciprocal of five, ceil(2^24 / 5). Exact for dividends below 2^22.
    localparam int                 DIV5_SHIFT = 24;
    localparam logic [21:0]        DIV5_RECIP = 22'd3355444;

    // Quotient by five of a 20-bit unsigned value.
    function automatic logic [17:0] div5_small(input logic [19:0] v);
        logic [43:0] prod;
        prod = 44'(v) * 44'(DIV5_RECIP);
        return prod[DIV5_SHIFT + 17:DIV5_SHIFT];
    endfunction

endpackage

### sv/jfps_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the two line stores of the stencil.
module jfps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2050
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while rd_en is low.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/jacobi_five_point_stencil.sv
// Top level of the streaming five-point Jacobi stencil: line stores, window,
// five-sample adder and a two-step divide by five.
// Depends on jfps_pkg and jfps_ram.
//
//  Channel   Direction  Handshake                  Payload
//  sample    in         sample_valid/sample_stall  sample (signed Q16.16)
//  result    out        result_valid/result_stall  average, sweep_end
//  cfg       in         cfg_valid/cfg_ready        grid_size
//
// One sample is taken every cycle while sample_stall is low; the line stores
// are read and written once per sample through separate ports, which sets that rate.
// A window's result passes the stage 1, sum, upper-digit and result registers.
// Reset clears the pipeline and the raster position and sets grid_size to
// 2048, or to MAX_GRID if that is smaller. The line stores need no clearing.
// A stall on the result side backs up through the pipeline stages; the input
// stalls only once every stage holds an item.
module jacobi_five_point_stencil #(
    parameter int MAX_GRID = jfps_pkg::MAX_GRID_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic signed [jfps_pkg::SAMPLE_W-1:0]  sample,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [jfps_pkg::SAMPLE_W-1:0]  average,
    output logic                                  sweep_end,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [jfps_pkg::CFG_W-1:0]            grid_size
);

    localparam int DEPTH   = MAX_GRID + 2;
    localparam int CNT_W   = $clog2(DEPTH);
    localparam int CMP_W   = ((CNT_W > jfps_pkg::CFG_W) ? CNT_W : jfps_pkg::CFG_W) + 1;
    localparam int SW      = jfps_pkg::SAMPLE_W;
    localparam int RESET_N =
        (jfps_pkg::GRID_RESET > MAX_GRID) ? MAX_GRID : jfps_pkg::GRID_RESET;
    localparam logic [CNT_W-1:0] RESET_LAST = CNT_W'(RESET_N + 1);

    // Configuration and raster position.
    logic [CNT_W-1:0] last_reg;
    logic [CNT_W-1:0] last_next;
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] row_reg;
    logic [CMP_W-1:0] gs_ext;
    logic [CMP_W-1:0] edge_ext;

    // Pipeline control.
    logic cfg_fire;
    logic in_fire;
    logic s1_fire;
    logic s2_ready;
    logic s3_ready;
    logic res_ready;

    // Stage 1: accepted sample, line store read data.
    logic                   s1_valid_reg;
    logic signed [SW-1:0]   s1_sample_reg;
    logic [CNT_W-1:0]       s1_col_reg;
    logic                   s1_emit_reg;
    logic                   s1_end_reg;
    logic [SW-1:0]          prev_rd;
    logic [SW-1:0]          older_rd;

    // Window around the point under work.
    logic signed [SW-1:0]   win_up_reg;
    logic signed [SW-1:0]   win_left_reg;
    logic signed [SW-1:0]   win_centre_reg;
    logic signed [SW-1:0]   win_down_reg;

    // Stage 2: offset sum.
    logic signed [jfps_pkg::SUM_W:0]   sum_wide;
    logic                              s2_valid_reg;
    logic [jfps_pkg::SUM_W-1:0]        s2_u_reg;
    logic                              s2_end_reg;

    // Stage 3: upper quotient digit.
    logic [17:0]            qhi_full;
    logic                   s3_valid_reg;
    logic [14:0]            s3_qhi_reg;
    logic [2:0]             s3_hilow_reg;
    logic [16:0]            s3_lo_reg;
    logic                   s3_end_reg;
    logic [2:0]             five_q_low;
    logic [2:0]             rem;
    logic [17:0]            qlo_full;

    // Result register.
    logic                   res_valid_reg;
    logic [SW-1:0]          res_avg_reg;
    logic                   res_end_reg;

    // Handshake chain from the result side back to the input.
    assign res_ready    = !res_valid_reg || !result_stall;
    assign s3_ready     = !s3_valid_reg || res_ready;
    assign s2_ready     = !s2_valid_reg || s3_ready;
    assign s1_fire      = s1_valid_reg && s2_ready;
    assign sample_stall = s1_valid_reg && !s2_ready;
    assign in_fire      = sample_valid && !sample_stall;
    assign cfg_ready    = 1'b1;
    assign cfg_fire     = cfg_valid && cfg_ready;

    // Edge length clamped to 1..MAX_GRID; the register keeps N + 1.
    always_comb
    begin
        gs_ext = CMP_W'(grid_size);
        priority if (gs_ext == '0)
        begin
            edge_ext = CMP_W'(1);
        end
        else if (gs_ext > CMP_W'(MAX_GRID))
        begin
            edge_ext = CMP_W'(MAX_GRID);
        end
        else
        begin
            edge_ext = gs_ext;
        end
        last_next = CNT_W'(edge_ext) + CNT_W'(1);
    end

    // Configuration register and raster counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= RESET_LAST;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else if (cfg_fire)
        begin
            last_reg <= last_next;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else if (in_fire)
        begin
            if (col_reg == last_reg)
            begin
                col_reg <= '0;
                row_reg <= (row_reg == last_reg) ? '0 : row_reg + CNT_W'(1);
            end
            else
            begin
                col_reg <= col_reg + CNT_W'(1);
            end
        end
    end

    // Line stores: the row above and the row two above.
    jfps_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_prev_store (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (s1_sample_reg),
        .rd_en   (in_fire),
        .rd_addr (col_reg),
        .rd_data (prev_rd)
    );

    jfps_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_older_store (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (prev_rd),
        .rd_en   (in_fire),
        .rd_addr (col_reg),
        .rd_data (older_rd)
    );

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_valid_reg || s2_ready)
            begin
                s1_valid_reg <= in_fire;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_fire && s1_emit_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (res_ready)
            begin
                res_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage 1 payload: sample and its raster flags.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sample_reg <= sample;
            s1_col_reg    <= col_reg;
            s1_emit_reg   <= (row_reg >= CNT_W'(2)) && (col_reg >= CNT_W'(2));
            s1_end_reg    <= (row_reg == last_reg) && (col_reg == last_reg);
        end
    end

    // Window shift as each sample leaves stage 1.
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            win_up_reg     <= older_rd;
            win_left_reg   <= win_centre_reg;
            win_centre_reg <= prev_rd;
            win_down_reg   <= s1_sample_reg;
        end
    end

    // Five-point sum plus rounding and lift offset.
    assign sum_wide = (jfps_pkg::SUM_W + 1)'(win_up_reg)
                    + (jfps_pkg::SUM_W + 1)'(win_left_reg)
                    + (jfps_pkg::SUM_W + 1)'(win_centre_reg)
                    + (jfps_pkg::SUM_W + 1)'($signed(prev_rd))
                    + (jfps_pkg::SUM_W + 1)'(win_down_reg)
                    + jfps_pkg::SUM_OFFSET;

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_u_reg   <= sum_wide[jfps_pkg::SUM_W-1:0];
            s2_end_reg <= s1_end_reg;
        end
    end

    // Upper digit: the top 18 bits divided by five.
    assign qhi_full = jfps_pkg::div5_small({2'b00, s2_u_reg[34:17]});

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_qhi_reg   <= qhi_full[14:0];
            s3_hilow_reg <= s2_u_reg[19:17];
            s3_lo_reg    <= s2_u_reg[16:0];
            s3_end_reg   <= s2_end_reg;
        end
    end

    // Lower digit: remainder of the upper digit joined to the low 17 bits.
    always_comb
    begin
        five_q_low = s3_qhi_reg[2:0] + {s3_qhi_reg[0], 2'b00};
        rem        = s3_hilow_reg - five_q_low;
        qlo_full   = jfps_pkg::div5_small({rem, s3_lo_reg});
    end

    // Result register; flipping the top bit removes the lift offset.
    always_ff @(posedge clk)
    begin
        if (res_ready)
        begin
            res_avg_reg <= {~s3_qhi_reg[14], s3_qhi_reg[13:0], qlo_full[16:0]};
            res_end_reg <= s3_end_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign average      = $signed(res_avg_reg);
    assign sweep_end    = res_end_reg;

endmodule

### sv/jfps_checker.sv
// Port-level checks for the five-point Jacobi stencil, bound to its top level.
// Depends on jacobi_five_point_stencil.
module jfps_assertions (
    input logic                clk,
    input logic                rst_n,
    input logic                sample_stall,
    input logic                result_valid,
    input logic                result_stall,
    input logic signed [31:0]  average,
    input logic                sweep_end
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(average) && $stable(sweep_end))
        else $error("result payload changed while stalled");

    // The input only stalls when a result is waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !sample_stall)
        else $error("input stalled with an empty output register");

    // The input only stalls while the result side holds off a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_stall)
        else $error("input stalled without a stall on the result side");

endmodule

bind jacobi_five_point_stencil jfps_assertions u_jfps_assertions (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .average      (average),
    .sweep_end    (sweep_end)
);
